### rtl/core/rgb888_to_lab888_unit_defines.svh
// Assertion macros for the rgb888_to_lab888 unit
`ifndef RGB888_TO_LAB888_UNIT_DEFINES_SVH
`define RGB888_TO_LAB888_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle
`define R2L_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that a condition holds at every clock edge out of reset
`define R2L_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`endif

### rtl/core/r2l_pkg.sv
// Package: types, constants and the linearization table for the RGB to Lab unit
package r2l_pkg;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_pixel_in;

    typedef struct packed {
        logic [6:0]        lightness;
        logic signed [7:0] green_red_axis;
        logic signed [7:0] blue_yellow_axis;
    } t_pixel_out;

    localparam logic [31:0] CBRT_BIAS = 32'h2a511cd0;

    // linear value in millionths of a percent
    function automatic logic [26:0] lin_micro(input logic [7:0] code);
        logic [26:0] micro;
        micro = '0;
        case (code)
            8'd0: micro = 27'd0; 8'd1: micro = 27'd30353; 8'd2: micro = 27'd60705;
            8'd3: micro = 27'd91058; 8'd4: micro = 27'd121411; 8'd5: micro = 27'd151763;
            8'd6: micro = 27'd182116; 8'd7: micro = 27'd212469; 8'd8: micro = 27'd242822;
            8'd9: micro = 27'd273174; 8'd10: micro = 27'd303527; 8'd11: micro = 27'd334654;
            8'd12: micro = 27'd367651; 8'd13: micro = 27'd402472; 8'd14: micro = 27'd439144;
            8'd15: micro = 27'd477695; 8'd16: micro = 27'd518152; 8'd17: micro = 27'd560539;
            8'd18: micro = 27'd604883; 8'd19: micro = 27'd651209; 8'd20: micro = 27'd699541;
            8'd21: micro = 27'd749903; 8'd22: micro = 27'd802319; 8'd23: micro = 27'd856813;
            8'd24: micro = 27'd913406; 8'd25: micro = 27'd972122; 8'd26: micro = 27'd1032982;
            8'd27: micro = 27'd1096009; 8'd28: micro = 27'd1161225; 8'd29: micro = 27'd1228649;
            8'd30: micro = 27'd1298303; 8'd31: micro = 27'd1370208; 8'd32: micro = 27'd1444384;
            8'd33: micro = 27'd1520851; 8'd34: micro = 27'd1599629; 8'd35: micro = 27'd1680738;
            8'd36: micro = 27'd1764195; 8'd37: micro = 27'd1850022; 8'd38: micro = 27'd1938236;
            8'd39: micro = 27'd2028856; 8'd40: micro = 27'd2121901; 8'd41: micro = 27'd2217388;
            8'd42: micro = 27'd2315337; 8'd43: micro = 27'd2415763; 8'd44: micro = 27'd2518686;
            8'd45: micro = 27'd2624122; 8'd46: micro = 27'd2732089; 8'd47: micro = 27'd2842604;
            8'd48: micro = 27'd2955683; 8'd49: micro = 27'd3071344; 8'd50: micro = 27'd3189603;
            8'd51: micro = 27'd3310477; 8'd52: micro = 27'd3433981; 8'd53: micro = 27'd3560131;
            8'd54: micro = 27'd3688945; 8'd55: micro = 27'd3820437; 8'd56: micro = 27'd3954624;
            8'd57: micro = 27'd4091520; 8'd58: micro = 27'd4231141; 8'd59: micro = 27'd4373503;
            8'd60: micro = 27'd4518620; 8'd61: micro = 27'd4666509; 8'd62: micro = 27'd4817182;
            8'd63: micro = 27'd4970657; 8'd64: micro = 27'd5126946; 8'd65: micro = 27'd5286065;
            8'd66: micro = 27'd5448028; 8'd67: micro = 27'd5612849; 8'd68: micro = 27'd5780543;
            8'd69: micro = 27'd5951124; 8'd70: micro = 27'd6124605; 8'd71: micro = 27'd6301002;
            8'd72: micro = 27'd6480327; 8'd73: micro = 27'd6662594; 8'd74: micro = 27'd6847817;
            8'd75: micro = 27'd7036010; 8'd76: micro = 27'd7227185; 8'd77: micro = 27'd7421357;
            8'd78: micro = 27'd7618538; 8'd79: micro = 27'd7818742; 8'd80: micro = 27'd8021982;
            8'd81: micro = 27'd8228271; 8'd82: micro = 27'd8437621; 8'd83: micro = 27'd8650046;
            8'd84: micro = 27'd8865559; 8'd85: micro = 27'd9084171; 8'd86: micro = 27'd9305896;
            8'd87: micro = 27'd9530747; 8'd88: micro = 27'd9758735; 8'd89: micro = 27'd9989873;
            8'd90: micro = 27'd10224173; 8'd91: micro = 27'd10461648; 8'd92: micro = 27'd10702310;
            8'd93: micro = 27'd10946171; 8'd94: micro = 27'd11193243; 8'd95: micro = 27'd11443537;
            8'd96: micro = 27'd11697067; 8'd97: micro = 27'd11953843; 8'd98: micro = 27'd12213877;
            8'd99: micro = 27'd12477182; 8'd100: micro = 27'd12743768;
            8'd101: micro = 27'd13013648; 8'd102: micro = 27'd13286832;
            8'd103: micro = 27'd13563333; 8'd104: micro = 27'd13843162;
            8'd105: micro = 27'd14126329; 8'd106: micro = 27'd14412847;
            8'd107: micro = 27'd14702727; 8'd108: micro = 27'd14995979;
            8'd109: micro = 27'd15292615; 8'd110: micro = 27'd15592646;
            8'd111: micro = 27'd15896084; 8'd112: micro = 27'd16202938;
            8'd113: micro = 27'd16513219; 8'd114: micro = 27'd16826940;
            8'd115: micro = 27'd17144110; 8'd116: micro = 27'd17464740;
            8'd117: micro = 27'd17788842; 8'd118: micro = 27'd18116424;
            8'd119: micro = 27'd18447499; 8'd120: micro = 27'd18782077;
            8'd121: micro = 27'd19120168; 8'd122: micro = 27'd19461783;
            8'd123: micro = 27'd19806932; 8'd124: micro = 27'd20155625;
            8'd125: micro = 27'd20507874; 8'd126: micro = 27'd20863687;
            8'd127: micro = 27'd21223076; 8'd128: micro = 27'd21586050;
            8'd129: micro = 27'd21952620; 8'd130: micro = 27'd22322796;
            8'd131: micro = 27'd22696587; 8'd132: micro = 27'd23074005;
            8'd133: micro = 27'd23455058; 8'd134: micro = 27'd23839757;
            8'd135: micro = 27'd24228112; 8'd136: micro = 27'd24620133;
            8'd137: micro = 27'd25015828; 8'd138: micro = 27'd25415209;
            8'd139: micro = 27'd25818285; 8'd140: micro = 27'd26225066;
            8'd141: micro = 27'd26635560; 8'd142: micro = 27'd27049779;
            8'd143: micro = 27'd27467731; 8'd144: micro = 27'd27889426;
            8'd145: micro = 27'd28314874; 8'd146: micro = 27'd28744084;
            8'd147: micro = 27'd29177065; 8'd148: micro = 27'd29613827;
            8'd149: micro = 27'd30054379; 8'd150: micro = 27'd30498731;
            8'd151: micro = 27'd30946892; 8'd152: micro = 27'd31398871;
            8'd153: micro = 27'd31854678; 8'd154: micro = 27'd32314321;
            8'd155: micro = 27'd32777810; 8'd156: micro = 27'd33245154;
            8'd157: micro = 27'd33716362; 8'd158: micro = 27'd34191442;
            8'd159: micro = 27'd34670406; 8'd160: micro = 27'd35153260;
            8'd161: micro = 27'd35640014; 8'd162: micro = 27'd36130678;
            8'd163: micro = 27'd36625260; 8'd164: micro = 27'd37123768;
            8'd165: micro = 27'd37626212; 8'd166: micro = 27'd38132601;
            8'd167: micro = 27'd38642943; 8'd168: micro = 27'd39157248;
            8'd169: micro = 27'd39675523; 8'd170: micro = 27'd40197778;
            8'd171: micro = 27'd40724021; 8'd172: micro = 27'd41254261;
            8'd173: micro = 27'd41788507; 8'd174: micro = 27'd42326767;
            8'd175: micro = 27'd42869050; 8'd176: micro = 27'd43415364;
            8'd177: micro = 27'd43965717; 8'd178: micro = 27'd44520119;
            8'd179: micro = 27'd45078578; 8'd180: micro = 27'd45641102;
            8'd181: micro = 27'd46207700; 8'd182: micro = 27'd46778380;
            8'd183: micro = 27'd47353150; 8'd184: micro = 27'd47932018;
            8'd185: micro = 27'd48514994; 8'd186: micro = 27'd49102085;
            8'd187: micro = 27'd49693300; 8'd188: micro = 27'd50288646;
            8'd189: micro = 27'd50888132; 8'd190: micro = 27'd51491767;
            8'd191: micro = 27'd52099557; 8'd192: micro = 27'd52711513;
            8'd193: micro = 27'd53327640; 8'd194: micro = 27'd53947949;
            8'd195: micro = 27'd54572446; 8'd196: micro = 27'd55201140;
            8'd197: micro = 27'd55834039; 8'd198: micro = 27'd56471151;
            8'd199: micro = 27'd57112483; 8'd200: micro = 27'd57758044;
            8'd201: micro = 27'd58407842; 8'd202: micro = 27'd59061884;
            8'd203: micro = 27'd59720179; 8'd204: micro = 27'd60382734;
            8'd205: micro = 27'd61049557; 8'd206: micro = 27'd61720656;
            8'd207: micro = 27'd62396039; 8'd208: micro = 27'd63075714;
            8'd209: micro = 27'd63759687; 8'd210: micro = 27'd64447968;
            8'd211: micro = 27'd65140564; 8'd212: micro = 27'd65837482;
            8'd213: micro = 27'd66538730; 8'd214: micro = 27'd67244316;
            8'd215: micro = 27'd67954247; 8'd216: micro = 27'd68668531;
            8'd217: micro = 27'd69387176; 8'd218: micro = 27'd70110189;
            8'd219: micro = 27'd70837578; 8'd220: micro = 27'd71569350;
            8'd221: micro = 27'd72305513; 8'd222: micro = 27'd73046074;
            8'd223: micro = 27'd73791041; 8'd224: micro = 27'd74540421;
            8'd225: micro = 27'd75294222; 8'd226: micro = 27'd76052450;
            8'd227: micro = 27'd76815115; 8'd228: micro = 27'd77582222;
            8'd229: micro = 27'd78353779; 8'd230: micro = 27'd79129794;
            8'd231: micro = 27'd79910274; 8'd232: micro = 27'd80695226;
            8'd233: micro = 27'd81484657; 8'd234: micro = 27'd82278575;
            8'd235: micro = 27'd83076988; 8'd236: micro = 27'd83879901;
            8'd237: micro = 27'd84687323; 8'd238: micro = 27'd85499261;
            8'd239: micro = 27'd86315721; 8'd240: micro = 27'd87136712;
            8'd241: micro = 27'd87962240; 8'd242: micro = 27'd88792312;
            8'd243: micro = 27'd89626935; 8'd244: micro = 27'd90466117;
            8'd245: micro = 27'd91309865; 8'd246: micro = 27'd92158186;
            8'd247: micro = 27'd93011086; 8'd248: micro = 27'd93868573;
            8'd249: micro = 27'd94730654; 8'd250: micro = 27'd95597335;
            8'd251: micro = 27'd96468625; 8'd252: micro = 27'd97344529;
            8'd253: micro = 27'd98225055; 8'd254: micro = 27'd99110210;
            8'd255: micro = 27'd100000000;
            default: micro = '0;
        endcase
        return micro;
    endfunction

    // linear ROM words: floor(lin * 256 / 1e6), 0..25600, built at elaboration
    function automatic logic [255:0][14:0] build_lin_words();
        logic [255:0][14:0] words;
        words = '0;
        for (int k = 0; k < 256; k++) begin
            words[k] = 15'((64'(lin_micro(8'(k))) * 64'd256) / 64'd1000000);
        end
        return words;
    endfunction

    localparam logic [255:0][14:0] LIN_WORDS = build_lin_words();

    function automatic logic [14:0] lin_word(input logic [7:0] code);
        return LIN_WORDS[code];
    endfunction

endpackage

### rtl/core/r2l_compand.sv
// Lab companding pipeline: float image, cube-root bit trick, back to fixed point
module r2l_compand #(
    parameter int FRAC_BITS = 16,
    parameter int TW        = 11 + FRAC_BITS
) (
    input  logic          i_clk,
    input  logic [TW-1:0] i_t,
    output logic [TW-1:0] o_f
);
    import r2l_pkg::*;

    localparam int PW = $clog2(TW);
    localparam logic [TW-1:0] THRESH = TW'((64'd8856 << FRAC_BITS) / 64'd1000000);
    localparam logic [TW-1:0] SLOPE  = TW'((64'd7787037 << FRAC_BITS) / 64'd1000000);
    localparam logic [TW-1:0] OFFSET = TW'((64'd137931 << FRAC_BITS) / 64'd1000000);

    // stage A: leading one, linear segment product
    logic [PW-1:0]   n_p;
    logic [PW-1:0]   r_p;
    logic [TW-1:0]   r_t;
    logic            r_hi;
    logic [2*TW-1:0] r_lin;

    always_comb begin
        n_p = '0;
        for (int k = 0; k < TW; k++) begin
            if (i_t[k]) begin
                n_p = PW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_t   <= i_t;
        r_hi  <= (i_t > THRESH);
        r_lin <= {{TW{1'b0}}, i_t} * {{TW{1'b0}}, SLOPE};
    end

    // stage B: normalize and round to single precision
    logic [31:0]     n_bits;
    logic [31:0]     r_bits;
    logic            r_hi_b;
    logic [TW-1:0]   r_lin_b;

    always_comb begin
        logic [TW+23:0] ext;
        logic [TW+23:0] sh;
        logic [24:0]    m;
        logic           g;
        logic           st;
        logic [8:0]     e;
        ext = {24'd0, r_t};
        sh  = ext << (6'd23 + 6'(TW) - 6'd1 - 6'(r_p));
        // sh holds the value with its leading one at bit TW+22
        m   = {1'b0, sh[TW+22 -: 24]};
        g   = sh[TW-2];
        st  = |sh[TW-3:0];
        if (g && (st || m[0])) begin
            m = m + 25'd1;
        end
        e = 9'(r_p) + 9'd127 - 9'(FRAC_BITS);
        if (m[24]) begin
            e = e + 9'd1;
            m = m >> 1;
        end
        n_bits = {1'b0, e[7:0], m[22:0]};
    end

    always_ff @(posedge i_clk) begin
        r_bits  <= n_bits;
        r_hi_b  <= r_hi;
        r_lin_b <= TW'(r_lin >> FRAC_BITS) + OFFSET;
    end

    // stage C: cube-root approximation on the bit image
    logic [31:0] n_cb;
    logic [31:0] r_cb;
    logic        r_hi_c;
    logic [TW-1:0] r_lin_c;

    always_comb begin
        logic [31:0] v;
        v    = (r_bits >> 2) + (r_bits >> 4);
        v    = v + (v >> 4);
        v    = v + (v >> 8);
        n_cb = v + CBRT_BIAS;
    end

    always_ff @(posedge i_clk) begin
        r_cb    <= n_cb;
        r_hi_c  <= r_hi_b;
        r_lin_c <= r_lin_b;
    end

    // stage D: back to fixed point, select segment
    logic [TW-1:0] n_f;

    always_comb begin
        logic signed [9:0] sh;
        logic [54:0]       mm;
        logic [54:0]       q;
        sh = 10'(r_cb[30:23]) - 10'sd127 - 10'sd23 + 10'(FRAC_BITS);
        mm = {31'd0, 1'b1, r_cb[22:0]};
        if (sh >= 0) begin
            q = mm << ((sh < 31) ? sh[4:0] : 5'd31);
        end else if (-sh >= 32) begin
            q = '0;
        end else begin
            q = mm >> (-sh);
        end
        n_f = r_hi_c ? TW'(q) : r_lin_c;
    end

    always_ff @(posedge i_clk) begin
        o_f <= n_f;
    end
endmodule

### rtl/core/rgb888_to_lab888_unit.sv
// Top level: streaming sRGB to CIELAB (D65) converter
// A valid bit travels with each pixel from start to o_done; one pixel accepted every cycle.
// Depth is set by the ROM, matrix, row-sum, white-point, companding, difference and output stages.
// busy is always low: the receiver cannot stall and nothing backs up.
// Reset clears only the valid pipeline; data registers are left as they are.
module rgb888_to_lab888_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  r2l_pkg::t_pixel_in  i_pixel,
    output logic                o_done,
    output r2l_pkg::t_pixel_out o_lab
);
    import r2l_pkg::*;
    `include "rgb888_to_lab888_unit_defines.svh"

    localparam int TW    = 11 + FRAC_BITS;
    localparam int DEPTH = 10;
    localparam logic [TW-1:0] C_XR = TW'((64'd4124 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_XG = TW'((64'd3576 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_XB = TW'((64'd1805 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_YR = TW'((64'd2126 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_YG = TW'((64'd7152 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_YB = TW'((64'd722 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_ZR = TW'((64'd193 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_ZG = TW'((64'd1192 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] C_ZB = TW'((64'd9505 << FRAC_BITS) / 64'd10000);
    localparam logic [TW-1:0] N_X  = TW'((64'd1000 << FRAC_BITS) / 64'd95047);
    localparam logic [TW-1:0] N_Y  = TW'((64'd1 << FRAC_BITS) / 64'd100);
    localparam logic [TW-1:0] N_Z  = TW'((64'd1000 << FRAC_BITS) / 64'd108883);

    logic [DEPTH-1:0] r_vld;
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start};
        end
    end

    // stage 1: linearize
    logic [TW-1:0] r_r, r_g, r_b;
    always_ff @(posedge i_clk) begin
        r_r <= TW'({lin_word(i_pixel.red_level), {(FRAC_BITS - 8){1'b0}}});
        r_g <= TW'({lin_word(i_pixel.green_level), {(FRAC_BITS - 8){1'b0}}});
        r_b <= TW'({lin_word(i_pixel.blue_level), {(FRAC_BITS - 8){1'b0}}});
    end

    // stage 2: nine matrix products
    logic [TW-1:0] r_m [9];
    always_ff @(posedge i_clk) begin
        r_m[0] <= TW'(({{TW{1'b0}}, r_r} * {{TW{1'b0}}, C_XR}) >> FRAC_BITS);
        r_m[1] <= TW'(({{TW{1'b0}}, r_g} * {{TW{1'b0}}, C_XG}) >> FRAC_BITS);
        r_m[2] <= TW'(({{TW{1'b0}}, r_b} * {{TW{1'b0}}, C_XB}) >> FRAC_BITS);
        r_m[3] <= TW'(({{TW{1'b0}}, r_r} * {{TW{1'b0}}, C_YR}) >> FRAC_BITS);
        r_m[4] <= TW'(({{TW{1'b0}}, r_g} * {{TW{1'b0}}, C_YG}) >> FRAC_BITS);
        r_m[5] <= TW'(({{TW{1'b0}}, r_b} * {{TW{1'b0}}, C_YB}) >> FRAC_BITS);
        r_m[6] <= TW'(({{TW{1'b0}}, r_r} * {{TW{1'b0}}, C_ZR}) >> FRAC_BITS);
        r_m[7] <= TW'(({{TW{1'b0}}, r_g} * {{TW{1'b0}}, C_ZG}) >> FRAC_BITS);
        r_m[8] <= TW'(({{TW{1'b0}}, r_b} * {{TW{1'b0}}, C_ZB}) >> FRAC_BITS);
    end

    // stage 3: row sums
    logic [TW-1:0] r_sx, r_sy, r_sz;
    always_ff @(posedge i_clk) begin
        r_sx <= r_m[0] + r_m[1] + r_m[2];
        r_sy <= r_m[3] + r_m[4] + r_m[5];
        r_sz <= r_m[6] + r_m[7] + r_m[8];
    end

    // stage 4: white-point scaling
    logic [TW-1:0] r_x, r_y, r_z;
    always_ff @(posedge i_clk) begin
        r_x <= TW'(({{TW{1'b0}}, r_sx} * {{TW{1'b0}}, N_X}) >> FRAC_BITS);
        r_y <= TW'(({{TW{1'b0}}, r_sy} * {{TW{1'b0}}, N_Y}) >> FRAC_BITS);
        r_z <= TW'(({{TW{1'b0}}, r_sz} * {{TW{1'b0}}, N_Z}) >> FRAC_BITS);
    end

    // stages 5..8: companding
    logic [TW-1:0] fx, fy, fz;
    r2l_compand #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_cx (.i_clk(i_clk), .i_t(r_x), .o_f(fx));
    r2l_compand #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_cy (.i_clk(i_clk), .i_t(r_y), .o_f(fy));
    r2l_compand #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_cz (.i_clk(i_clk), .i_t(r_z), .o_f(fz));

    // stage 9: differences and products
    logic [TW+9:0] r_lp, r_ap, r_bp;
    logic          r_an, r_bn;
    always_ff @(posedge i_clk) begin
        r_lp <= {10'd0, fy} * (TW + 10)'(116);
        r_an <= fx < fy;
        r_ap <= (fx >= fy) ? {10'd0, fx - fy} * (TW + 10)'(500)
                           : {10'd0, fy - fx} * (TW + 10)'(500);
        r_bn <= fy < fz;
        r_bp <= (fy >= fz) ? {10'd0, fy - fz} * (TW + 10)'(200)
                           : {10'd0, fz - fy} * (TW + 10)'(200);
    end

    // stage 10: truncate and saturate
    t_pixel_out n_lab;
    always_comb begin
        logic [TW+9:0] li, ai, bi;
        li = r_lp >> FRAC_BITS;
        ai = r_ap >> FRAC_BITS;
        bi = r_bp >> FRAC_BITS;
        if (li < (TW + 10)'(16)) begin
            n_lab.lightness = 7'd0;
        end else if (li > (TW + 10)'(116)) begin
            n_lab.lightness = 7'd100;
        end else begin
            n_lab.lightness = 7'(li - (TW + 10)'(16));
        end
        if (ai > (TW + 10)'(127)) begin
            n_lab.green_red_axis = r_an ? -8'sd127 : 8'sd127;
        end else begin
            n_lab.green_red_axis = r_an ? -$signed(8'(ai)) : $signed(8'(ai));
        end
        if (bi > (TW + 10)'(127)) begin
            n_lab.blue_yellow_axis = r_bn ? -8'sd127 : 8'sd127;
        end else begin
            n_lab.blue_yellow_axis = r_bn ? -$signed(8'(bi)) : $signed(8'(bi));
        end
    end

    always_ff @(posedge i_clk) begin
        o_lab <= n_lab;
    end
    assign o_done = r_vld[DEPTH-1];

    `R2L_ASSERT_NEXT(a_start_flows, i_clk, i_rst_n, start, r_vld[0])
    `R2L_ASSERT_ALWAYS(a_light_range, i_clk, i_rst_n, !o_done || o_lab.lightness <= 7'd100)
    `R2L_ASSERT_ALWAYS(a_ga_range, i_clk, i_rst_n, !o_done || o_lab.green_red_axis != -8'sd128)
    `R2L_ASSERT_ALWAYS(a_by_range, i_clk, i_rst_n, !o_done || o_lab.blue_yellow_axis != -8'sd128)
endmodule
